// ===== rtl/core/mp2_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the line store address map of the max pooling block.
// No dependencies; every module of the block imports this package.
package mp2_pkg;

  // Size limits of the design
  localparam int MAX_EXTENT   = 8;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_CHANNELS = 512;
  localparam int MAX_STRIDE   = 8;

  // Field widths fixed by the interface
  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int EXT_RAW_W  = 4;
  localparam int STR_RAW_W  = 4;
  localparam int HGT_RAW_W  = 9;
  localparam int WID_RAW_W  = 9;
  localparam int CHN_RAW_W  = 10;

  // Internal widths derived from the limits
  localparam int EXT_W       = $clog2(MAX_EXTENT + 1);
  localparam int STR_W       = $clog2(MAX_STRIDE + 1);
  localparam int PHASE_W     = $clog2(MAX_STRIDE);
  localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
  localparam int WID_W       = $clog2(MAX_WIDTH + 1);
  localparam int CHN_W       = $clog2(MAX_CHANNELS + 1);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SLOT_W      = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
  localparam int ROWBASE_W   = $clog2(MAX_HEIGHT * MAX_WIDTH);
  localparam int PLANE_W     = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
  localparam int STORE_DEPTH = MAX_EXTENT * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Queue depths (powers of two)
  localparam int JQ_DEPTH = 2;
  localparam int OQ_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT   = 3'd0,
    REG_STRIDE   = 3'd1,
    REG_HEIGHT   = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_CHANNELS = 3'd4
  } reg_index_t;

  // Effective (clamped) settings plus derived products
  typedef struct packed {
    logic [EXT_W-1:0]     ext;
    logic [STR_W-1:0]     str;
    logic [HGT_W-1:0]     hgt;
    logic [WID_W-1:0]     wid;
    logic [CHN_W-1:0]     chn;
    logic [PLANE_W-1:0]   plane;
    logic [ROWBASE_W-1:0] ext_m1_wid;
  } cfg_t;

  // Line store write request from the front
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } store_wr_t;

  // One window scan request
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  c0;
    logic [IDX_W-1:0]  base;
    logic              last;
  } job_t;

  // One pooled result
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           index;
    logic                       last;
  } result_t;

  // Row slot and column to line store address
  function automatic logic [ADDR_W-1:0] line_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/core/max_pool_2d_with_argmax.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 2-D max pooling block with argmax.
// Depends on mp2_pkg, mp2_cfg, mp2_front, mp2_job_queue, mp2_back.
//
//  channel   handshake              payload
//  -------   ---------------------  --------------------------------------
//  samples   push / full            sample[15:0] signed
//  results   pop / empty            pooled_value, source_index, last_of_tensor
//  config    write_enable           reg_index[2:0], write_data[9:0]
//
// A sample passes the front end in the cycle it is accepted. Each completed
// window is scanned in the back end, which reads its extent*extent entries
// through the single read port of the line store (one entry per cycle).
// At the start of a new row the front holds full while earlier windows are
// still being scanned. Reset is synchronous; full stays high for one cycle
// after reset and after each write to a defined register. Up to two requests
// and two results are buffered, so a short stall on either side does not block the other.
module max_pool_2d_with_argmax (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [15:0]             sample,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [15:0]             pooled_value,
  output logic [24:0]                    source_index,
  output logic                           last_of_tensor,
  input  logic                           write_enable,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0] write_data
);
  import mp2_pkg::*;

  cfg_t      cfg;
  logic      settle, restart;
  logic      back_busy, jq_full, jq_empty, jq_pop, job_push;
  job_t      job_in, job_out;
  store_wr_t store_wr;
  result_t   result;

  mp2_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg),
    .settle       (settle),
    .restart      (restart)
  );

  mp2_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .cfg       (cfg),
    .settle    (settle),
    .restart   (restart),
    .back_busy (back_busy),
    .jq_full   (jq_full),
    .jq_empty  (jq_empty),
    .job_push  (job_push),
    .job       (job_in),
    .store_wr  (store_wr)
  );

  mp2_job_queue u_jq (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .pop     (jq_pop),
    .job_out (job_out),
    .full    (jq_full),
    .empty   (jq_empty)
  );

  mp2_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .store_wr (store_wr),
    .jq_empty (jq_empty),
    .job      (job_out),
    .jq_pop   (jq_pop),
    .busy     (back_busy),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

  assign pooled_value   = result.value;
  assign source_index   = result.index;
  assign last_of_tensor = result.last;

  // A scan request is never dropped by the request queue
  assert property (@(posedge clk) disable iff (rst) job_push |-> !jq_full)
    else $error("scan request issued into a full request queue");

  // Every store write is an accepted sample and vice versa
  assert property (@(posedge clk) disable iff (rst) store_wr.en == (push && !full))
    else $error("line store write out of step with sample acceptance");

  // A register write holds off samples on the next cycle
  assert property (@(posedge clk) disable iff (rst)
      (write_enable && (reg_index == REG_EXTENT || reg_index == REG_STRIDE ||
       reg_index == REG_HEIGHT || reg_index == REG_WIDTH ||
       reg_index == REG_CHANNELS)) |=> full)
    else $error("samples accepted right after a register write");

  // Nothing is waiting right after reset
  assert property (@(posedge clk) rst |=> (empty && jq_empty && !back_busy))
    else $error("queues not empty after reset");

endmodule

// ===== rtl/core/mp2_cfg.sv =====
`timescale 1ns / 1ps
// Configuration registers, range clamping and derived plane products.
// Depends on mp2_pkg.
module mp2_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0] write_data,
  output mp2_pkg::cfg_t                  cfg,
  output logic                           settle,
  output logic                           restart
);
  import mp2_pkg::*;

  logic [EXT_RAW_W-1:0] ext_raw;
  logic [STR_RAW_W-1:0] str_raw;
  logic [HGT_RAW_W-1:0] hgt_raw;
  logic [WID_RAW_W-1:0] wid_raw;
  logic [CHN_RAW_W-1:0] chn_raw;
  logic                 idx_ok;
  cfg_t                 cfg_next;

  // Index decode
  always_comb begin
    idx_ok = 1'b1;
    unique case (reg_index)
      REG_EXTENT, REG_STRIDE, REG_HEIGHT, REG_WIDTH, REG_CHANNELS: idx_ok = 1'b1;
      default: idx_ok = 1'b0;
    endcase
  end

  assign restart = write_enable && idx_ok;

  // Raw registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_raw <= EXT_RAW_W'(2);
      str_raw <= STR_RAW_W'(2);
      hgt_raw <= HGT_RAW_W'(32);
      wid_raw <= WID_RAW_W'(32);
      chn_raw <= CHN_RAW_W'(1);
    end else if (write_enable) begin
      unique case (reg_index)
        REG_EXTENT:   ext_raw <= write_data[EXT_RAW_W-1:0];
        REG_STRIDE:   str_raw <= write_data[STR_RAW_W-1:0];
        REG_HEIGHT:   hgt_raw <= write_data[HGT_RAW_W-1:0];
        REG_WIDTH:    wid_raw <= write_data[WID_RAW_W-1:0];
        REG_CHANNELS: chn_raw <= write_data[CHN_RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the supported range; zero reads as one
  always_comb begin
    cfg_next.ext = (ext_raw == '0) ? EXT_W'(1) :
                   (ext_raw > MAX_EXTENT) ? EXT_W'(MAX_EXTENT) : EXT_W'(ext_raw);
    cfg_next.str = (str_raw == '0) ? STR_W'(1) :
                   (str_raw > MAX_STRIDE) ? STR_W'(MAX_STRIDE) : STR_W'(str_raw);
    cfg_next.hgt = (hgt_raw == '0) ? HGT_W'(1) :
                   (hgt_raw > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT) : HGT_W'(hgt_raw);
    cfg_next.wid = (wid_raw == '0) ? WID_W'(1) :
                   (wid_raw > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(wid_raw);
    cfg_next.chn = (chn_raw == '0) ? CHN_W'(1) :
                   (chn_raw > MAX_CHANNELS) ? CHN_W'(MAX_CHANNELS) : CHN_W'(chn_raw);
    cfg_next.plane = PLANE_W'(PLANE_W'(cfg_next.hgt) * PLANE_W'(cfg_next.wid));
    cfg_next.ext_m1_wid = ROWBASE_W'(ROWBASE_W'(cfg_next.ext - 1'b1) *
                                     ROWBASE_W'(cfg_next.wid));
  end

  // Registered settings; settle holds off samples for one cycle after a change
  always_ff @(posedge clk) begin
    cfg <= cfg_next;
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= restart;
    end
  end

endmodule

// ===== rtl/core/mp2_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, tracks position and stride phases, writes the
// line store and issues window scan requests. Depends on mp2_pkg.
module mp2_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [mp2_pkg::SAMPLE_W-1:0] sample,
  output logic                         full,
  input  mp2_pkg::cfg_t                cfg,
  input  logic                         settle,
  input  logic                         restart,
  input  logic                         back_busy,
  input  logic                         jq_full,
  input  logic                         jq_empty,
  output logic                         job_push,
  output mp2_pkg::job_t                job,
  output mp2_pkg::store_wr_t           store_wr
);
  import mp2_pkg::*;

  localparam int SW = EXT_W + 1;

  // Position state
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [CH_W-1:0]      ch;
  logic [PHASE_W-1:0]   rphase, cphase;
  logic [SLOT_W-1:0]    slot;
  logic [ROWBASE_W-1:0] row_base;
  logic [IDX_W-1:0]     ch_base;

  // Effective position after the range guard
  logic                 guard, hit, pending, accept;
  logic [ROW_W-1:0]     r_v;
  logic [COL_W-1:0]     c_v;
  logic [CH_W-1:0]      ch_v;
  logic [PHASE_W-1:0]   rp_v, cp_v;
  logic [SLOT_W-1:0]    slot_v;
  logic [ROWBASE_W-1:0] rb_v;
  logic [IDX_W-1:0]     cb_v;
  logic [HGT_W-1:0]     r1;
  logic [WID_W-1:0]     c1;
  logic [EXT_W-1:0]     ext_m1;
  logic [SW-1:0]        org;
  logic                 row_ok, col_ok, tail_r, tail_c;

  // Next position
  logic [ROW_W-1:0]     row_next;
  logic [COL_W-1:0]     col_next;
  logic [CH_W-1:0]      ch_next;
  logic [PHASE_W-1:0]   rphase_next, cphase_next;
  logic [SLOT_W-1:0]    slot_next;
  logic [ROWBASE_W-1:0] row_base_next;
  logic [IDX_W-1:0]     ch_base_next;

  // Stall at the start of a row (also a new plane of a one-row tensor)
  // while older windows may still read the store
  assign pending = back_busy || !jq_empty;
  assign full    = settle || jq_full || (pending && (col == '0));
  assign accept  = push && !full;

  // Window detection and request fields
  always_comb begin
    guard  = (HGT_W'(row) >= cfg.hgt) || (WID_W'(col) >= cfg.wid) ||
             (CHN_W'(ch) >= cfg.chn);
    r_v    = guard ? '0 : row;
    c_v    = guard ? '0 : col;
    ch_v   = guard ? '0 : ch;
    rp_v   = guard ? '0 : rphase;
    cp_v   = guard ? '0 : cphase;
    slot_v = guard ? '0 : slot;
    rb_v   = guard ? '0 : row_base;
    cb_v   = guard ? '0 : ch_base;

    r1     = HGT_W'(r_v) + 1'b1;
    c1     = WID_W'(c_v) + 1'b1;
    row_ok = r1 >= HGT_W'(cfg.ext);
    col_ok = c1 >= WID_W'(cfg.ext);
    hit    = row_ok && col_ok && (rp_v == '0) && (cp_v == '0);

    // top row of the window in the circular row slots
    ext_m1 = cfg.ext - 1'b1;
    if (SW'(slot_v) >= SW'(ext_m1)) begin
      org = SW'(slot_v) - SW'(ext_m1);
    end else begin
      org = SW'(slot_v) + SW'(MAX_EXTENT) - SW'(ext_m1);
    end

    tail_r = (HGT_W+1)'(r_v) + (HGT_W+1)'(cfg.str) >= (HGT_W+1)'(cfg.hgt);
    tail_c = (WID_W+1)'(c_v) + (WID_W+1)'(cfg.str) >= (WID_W+1)'(cfg.wid);

    job.slot = SLOT_W'(org);
    job.c0   = COL_W'(c1 - WID_W'(cfg.ext));
    job.base = cb_v + IDX_W'(rb_v) - IDX_W'(cfg.ext_m1_wid);
    job.last = ((CHN_W'(ch_v) + 1'b1) == cfg.chn) && tail_r && tail_c;

    job_push = accept && hit;

    store_wr.en   = accept;
    store_wr.addr = line_addr(slot_v, c_v);
    store_wr.data = sample;
  end

  // Position advance
  always_comb begin
    row_next      = r_v;
    col_next      = COL_W'(c1);
    ch_next       = ch_v;
    rphase_next   = rp_v;
    cphase_next   = cp_v;
    slot_next     = slot_v;
    row_base_next = rb_v;
    ch_base_next  = cb_v;
    if (col_ok) begin
      cphase_next = ((STR_W'(cp_v) + 1'b1) >= cfg.str) ? '0 : cp_v + 1'b1;
    end
    if (c1 >= cfg.wid) begin
      col_next    = '0;
      cphase_next = '0;
      if (row_ok) begin
        rphase_next = ((STR_W'(rp_v) + 1'b1) >= cfg.str) ? '0 : rp_v + 1'b1;
      end
      row_next      = ROW_W'(r1);
      row_base_next = rb_v + ROWBASE_W'(cfg.wid);
      slot_next     = (slot_v == SLOT_W'(MAX_EXTENT - 1)) ? '0 : slot_v + 1'b1;
      if (r1 >= cfg.hgt) begin
        row_next      = '0;
        rphase_next   = '0;
        row_base_next = '0;
        slot_next     = '0;
        if ((CHN_W'(ch_v) + 1'b1) >= cfg.chn) begin
          ch_next      = '0;
          ch_base_next = '0;
        end else begin
          ch_next      = ch_v + 1'b1;
          ch_base_next = cb_v + IDX_W'(cfg.plane);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row      <= '0;
      col      <= '0;
      ch       <= '0;
      rphase   <= '0;
      cphase   <= '0;
      slot     <= '0;
      row_base <= '0;
      ch_base  <= '0;
    end else if (accept) begin
      row      <= row_next;
      col      <= col_next;
      ch       <= ch_next;
      rphase   <= rphase_next;
      cphase   <= cphase_next;
      slot     <= slot_next;
      row_base <= row_base_next;
      ch_base  <= ch_base_next;
    end
  end

endmodule

// ===== rtl/core/mp2_job_queue.sv =====
`timescale 1ns / 1ps
// Short queue of window scan requests between front and back.
// Depends on mp2_pkg.
module mp2_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mp2_pkg::job_t job_in,
  input  logic          pop,
  output mp2_pkg::job_t job_out,
  output logic          full,
  output logic          empty
);
  import mp2_pkg::*;

  localparam int PTR_W = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(JQ_DEPTH + 1);

  job_t             slots [JQ_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] cnt;
  logic             do_push, do_pop;

  assign full    = (cnt == CNT_W'(JQ_DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = slots[rp];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop)  rp <= rp + 1'b1;
      cnt <= cnt + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= job_in;
    end
  end

endmodule

// ===== rtl/core/mp2_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the line store, scans one window per request row-major,
// keeps the running maximum and queues results. Depends on mp2_pkg.
module mp2_back (
  input  logic               clk,
  input  logic               rst,
  input  mp2_pkg::cfg_t      cfg,
  input  mp2_pkg::store_wr_t store_wr,
  input  logic               jq_empty,
  input  mp2_pkg::job_t      job,
  output logic               jq_pop,
  output logic               busy,
  input  logic               pop,
  output logic               empty,
  output mp2_pkg::result_t   result
);
  import mp2_pkg::*;

  localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Line store
  logic [SAMPLE_W-1:0] store [STORE_DEPTH];

  // Scan control
  logic                active, first, tl, start, last_col, last_row, issue_last;
  logic [SLOT_W-1:0]   slot;
  logic [COL_W-1:0]    col, c0;
  logic [EXT_W-1:0]    ri, cj;
  logic [IDX_W-1:0]    row_idx;

  // Read data stage
  logic                       d_valid, d_first, d_last, d_tl, take, res_push;
  logic [SAMPLE_W-1:0]        rd_data;
  logic [IDX_W-1:0]           d_index, new_idx, best_idx;
  logic signed [SAMPLE_W-1:0] best, new_best;

  // Result queue
  result_t             oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wp, rp;
  logic [OQ_CNT_W-1:0] cnt;
  logic                pop_ok;

  assign start      = !active && !jq_empty && !d_valid && (cnt < OQ_CNT_W'(OQ_DEPTH));
  assign jq_pop     = start;
  assign last_col   = (cj == cfg.ext - 1'b1);
  assign last_row   = (ri == cfg.ext - 1'b1);
  assign issue_last = active && last_col && last_row;
  assign busy       = active || d_valid;

  // Strict compare keeps the first maximum in scan order
  always_comb begin
    take     = d_first || ($signed(rd_data) > best);
    new_best = take ? $signed(rd_data) : best;
    new_idx  = take ? d_index : best_idx;
    res_push = d_valid && d_last;
    pop_ok   = pop && (cnt != '0);
  end

  assign empty  = (cnt == '0);
  assign result = oq[rp];

  // Line store write port and registered read port
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
    if (active) begin
      rd_data <= store[line_addr(slot, col)];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      d_valid <= 1'b0;
      wp      <= '0;
      rp      <= '0;
      cnt     <= '0;
    end else begin
      d_valid <= active;
      if (start) begin
        active <= 1'b1;
      end else if (issue_last) begin
        active <= 1'b0;
      end
      if (res_push) wp <= wp + 1'b1;
      if (pop_ok)   rp <= rp + 1'b1;
      cnt <= cnt + OQ_CNT_W'(res_push) - OQ_CNT_W'(pop_ok);
    end
  end

  // Scan walk: columns inside a row, then next row slot
  always_ff @(posedge clk) begin
    if (start) begin
      slot    <= job.slot;
      col     <= job.c0;
      c0      <= job.c0;
      ri      <= '0;
      cj      <= '0;
      row_idx <= job.base;
      tl      <= job.last;
      first   <= 1'b1;
    end else if (active) begin
      first <= 1'b0;
      if (last_col) begin
        cj      <= '0;
        col     <= c0;
        ri      <= ri + 1'b1;
        slot    <= (slot == SLOT_W'(MAX_EXTENT - 1)) ? '0 : slot + 1'b1;
        row_idx <= row_idx + IDX_W'(cfg.wid);
      end else begin
        cj  <= cj + 1'b1;
        col <= col + 1'b1;
      end
    end
    d_first <= first;
    d_last  <= issue_last;
    d_index <= row_idx + IDX_W'(col);
    d_tl    <= tl;
    if (d_valid) begin
      best     <= new_best;
      best_idx <= new_idx;
    end
    if (res_push) begin
      oq[wp] <= '{value: new_best, index: new_idx, last: d_tl};
    end
  end

endmodule

// ===== bench/max_pool_2d_with_argmax_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for max_pool_2d_with_argmax: a cycle-free pooling predictor,
// random push/pop pacing and field-by-field result checks. Depends on mp2_pkg.
module max_pool_2d_with_argmax_test;
  import mp2_pkg::*;

  localparam int unsigned TARGET_ITEMS  = 1800;
  localparam int unsigned SETTLE_CYCLES = MAX_EXTENT * MAX_EXTENT + 40;
  // indexes past the register map, ignored by the block
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd5;
  localparam int unsigned SPARE_REGS = 3;

  logic                    clk;
  logic                    rst;
  logic                    push;
  logic                    full;
  logic signed [15:0]      sample;
  logic                    empty;
  logic                    pop;
  logic signed [15:0]      pooled_value;
  logic [24:0]             source_index;
  logic                    last_of_tensor;
  logic                    write_enable;
  logic [CFG_IDX_W-1:0]    reg_index;
  logic [CFG_DATA_W-1:0]   write_data;

  max_pool_2d_with_argmax u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop),
    .pooled_value(pooled_value), .source_index(source_index),
    .last_of_tensor(last_of_tensor),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data)
  );

  // Raw register copies, as written
  logic [EXT_RAW_W-1:0] ext_raw;
  logic [STR_RAW_W-1:0] str_raw;
  logic [HGT_RAW_W-1:0] hgt_raw;
  logic [WID_RAW_W-1:0] wid_raw;
  logic [CHN_RAW_W-1:0] chn_raw;

  // Stream position and window phases of the predictor
  logic signed [15:0] rows_kept [0:STORE_DEPTH-1];
  int unsigned col_pos, row_pos, chan_pos, row_ph, col_ph;

  result_t     pending_pools [$];
  int unsigned sent_items;
  int unsigned fail_count;
  bit          gaps_on;
  bit          stalls_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int unsigned clamp_setting(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_stream();
    col_pos = 0;
    row_pos = 0;
    chan_pos = 0;
    row_ph = 0;
    col_ph = 0;
  endtask

  task automatic reset_prediction();
    ext_raw = 2;
    str_raw = 2;
    hgt_raw = 32;
    wid_raw = 32;
    chn_raw = 1;
    foreach (rows_kept[i]) rows_kept[i] = '0;
    restart_stream();
  endtask

  // Register write as the block sees it; spare indexes change nothing
  task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_EXTENT:   ext_raw = val[EXT_RAW_W-1:0];
      REG_STRIDE:   str_raw = val[STR_RAW_W-1:0];
      REG_HEIGHT:   hgt_raw = val[HGT_RAW_W-1:0];
      REG_WIDTH:    wid_raw = val[WID_RAW_W-1:0];
      REG_CHANNELS: chn_raw = val[CHN_RAW_W-1:0];
      default:      return;
    endcase
    restart_stream();
  endtask

  // Store one sample, scan the window it completes, advance the position
  task automatic predict_pool(input logic signed [15:0] value);
    int unsigned ext, str, hgt, wid, chn, r, c, r0, c0, best_r, best_c;
    logic signed [15:0] best, cand;
    longint unsigned flat;
    result_t res;
    ext = clamp_setting(ext_raw, MAX_EXTENT);
    str = clamp_setting(str_raw, MAX_STRIDE);
    hgt = clamp_setting(hgt_raw, MAX_HEIGHT);
    wid = clamp_setting(wid_raw, MAX_WIDTH);
    chn = clamp_setting(chn_raw, MAX_CHANNELS);
    if (row_pos >= hgt || col_pos >= wid || chan_pos >= chn) restart_stream();
    r = row_pos;
    c = col_pos;
    rows_kept[(r % MAX_EXTENT) * MAX_WIDTH + c] = value;

    if (r + 1 >= ext && c + 1 >= ext && row_ph == 0 && col_ph == 0) begin
      r0 = r + 1 - ext;
      c0 = c + 1 - ext;
      best_r = r0;
      best_c = c0;
      best = rows_kept[(r0 % MAX_EXTENT) * MAX_WIDTH + c0];
      // strict compare keeps the first maximum in row-major order
      for (int unsigned i = 0; i < ext; i++) begin
        for (int unsigned j = 0; j < ext; j++) begin
          cand = rows_kept[((r0 + i) % MAX_EXTENT) * MAX_WIDTH + c0 + j];
          if (cand > best) begin
            best = cand;
            best_r = r0 + i;
            best_c = c0 + j;
          end
        end
      end
      flat = longint'(chan_pos) * hgt * wid + longint'(best_r) * wid + best_c;
      res.value = best;
      res.index = flat[IDX_W-1:0];
      res.last = (chan_pos + 1 == chn) && (r + str >= hgt) && (c + str >= wid);
      pending_pools = {pending_pools, res};
    end

    if (c + 1 >= ext) col_ph = (col_ph + 1 >= str) ? 0 : col_ph + 1;
    c++;
    if (c >= wid) begin
      c = 0;
      col_ph = 0;
      if (r + 1 >= ext) row_ph = (row_ph + 1 >= str) ? 0 : row_ph + 1;
      r++;
      if (r >= hgt) begin
        r = 0;
        row_ph = 0;
        chan_pos++;
        if (chan_pos >= chn) chan_pos = 0;
      end
    end
    col_pos = c;
    row_pos = r;
  endtask

  // Send one sample request; leaves push high so back-to-back requests need no gap
  task automatic push_sample(input logic signed [15:0] value);
    int unsigned gap;
    logic taken;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    sample <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (full === 1'b0);
      @(posedge clk);
    end
    predict_pool(value);
    sent_items++;
  endtask

  // Quiet the input side, drain results, then let the back end finish
  task automatic settle_idle();
    push <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    apply_setting(idx, val);
    @(posedge clk);
  endtask

  task automatic set_shape(input int unsigned ext, input int unsigned str,
                           input int unsigned hgt, input int unsigned wid,
                           input int unsigned chn);
    settle_idle();
    write_setting(REG_EXTENT, CFG_DATA_W'(ext));
    write_setting(REG_STRIDE, CFG_DATA_W'(str));
    write_setting(REG_HEIGHT, CFG_DATA_W'(hgt));
    write_setting(REG_WIDTH, CFG_DATA_W'(wid));
    write_setting(REG_CHANNELS, CFG_DATA_W'(chn));
  endtask

  // Full-range value, or a narrow band around zero to force ties
  function automatic logic signed [15:0] rand_sample(input bit tie_heavy);
    if (tie_heavy && $urandom_range(0, 3) != 0) return 16'($urandom_range(0, 4)) - 16'sd2;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic send_random(input int unsigned count, input bit tie_heavy);
    repeat (count) push_sample(rand_sample(tie_heavy));
  endtask

  // Reset settings: 2x2 window, stride 2, 32x32 plane
  task automatic test_reset_defaults();
    send_random(70, 1'b0);
  endtask

  // 1x1 windows pass every sample through: sign and bit pattern extremes
  task automatic test_value_extremes();
    logic signed [15:0] patterns [10];
    patterns = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
                 16'sh5555, 16'shAAAA, 16'sh0100, 16'sh8001, 16'sh7FFE};
    set_shape(1, 1, 2, 4, 2);
    foreach (patterns[i]) push_sample(patterns[i]);
    send_random(6, 1'b0);
  endtask

  // Equal maxima pick the first in scan order; spare indexes must not restart
  task automatic test_ties_and_spare_regs();
    set_shape(2, 1, 2, 3, 1);
    push_sample(16'sd7);
    push_sample(16'sd3);
    push_sample(16'sd7);
    settle_idle();
    for (int unsigned k = 0; k < SPARE_REGS; k++)
      write_setting(FIRST_SPARE_REG + CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, 1023)));
    push_sample(16'sd7);
    push_sample(16'sd7);
    push_sample(16'sd1);
  endtask

  // Window larger than the plane never completes
  task automatic test_oversized_window();
    set_shape(4, 1, 2, 2, 1);
    send_random(4, 1'b0);
  endtask

  // Zero settings read as 1; every sample is its own plane up to 512 channels
  task automatic test_channel_limit();
    set_shape(0, 0, 0, 0, MAX_CHANNELS);
    send_random(MAX_CHANNELS + 20, 1'b0);
  endtask

  // Tallest plane, one column wide
  task automatic test_tall_plane();
    set_shape(1, 1, MAX_HEIGHT, 1, 1);
    send_random(MAX_HEIGHT + 4, 1'b1);
  endtask

  // Width and channels above range saturate; the row must wrap at 256
  task automatic test_wide_saturated();
    set_shape(2, 2, 2, 300, 1023);
    send_random(270, 1'b1);
  endtask

  // Extent and stride above range read as 8
  task automatic test_large_window();
    set_shape(15, 9, 511, 8, 2);
    send_random(128, 1'b1);
  endtask

  // Random shapes: mostly whole tensors, some wraps into the next one,
  // some cut short, now and then a window that cannot fit
  task automatic test_random_shapes();
    int unsigned e, st, h, w, ch, n, plane, kind, phase;
    int unsigned e_raw;
    bit tie_heavy;
    phase = 0;
    plane = 1;
    while (sent_items < TARGET_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      tie_heavy = ($urandom_range(0, 1) != 0);
      if (phase == 0 || $urandom_range(0, 7) != 0) begin
        e = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 3) : $urandom_range(1, MAX_EXTENT);
        st = ($urandom_range(0, 2) == 0) ? $urandom_range(1, MAX_STRIDE) : $urandom_range(1, 3);
        h = $urandom_range(e, e + 5);
        w = $urandom_range(e, e + 7);
        ch = $urandom_range(1, 3);
        if ($urandom_range(0, 11) == 0) begin
          e = $urandom_range(2, MAX_EXTENT);
          h = $urandom_range(1, 4);
          w = $urandom_range(1, 4);
        end
        plane = h * w * ch;
        e_raw = e;
        if (e == MAX_EXTENT && $urandom_range(0, 1)) e_raw = $urandom_range(MAX_EXTENT + 1, 15);
        if (st == 1 && $urandom_range(0, 1)) st = 0;
        set_shape(e_raw, st, h, w, ch);
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) n = plane;
      else if (kind < 8) n = plane + $urandom_range(1, plane);
      else n = $urandom_range(1, plane);
      if (n > 240) n = 240;
      send_random(n, tie_heavy);
      phase++;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Result side: random pop pacing, compare against the oldest expectation
  initial begin : result_checker
    int unsigned stall;
    logic taken;
    result_t want;
    pop = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = stalls_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        if (empty === 1'b0) begin
          taken = 1'b1;
          if (pending_pools.size() == 0) begin
            note_mismatch($sformatf("unexpected result value %0d index %0d",
                                    pooled_value, source_index));
          end else begin
            want = pending_pools.pop_front();
            if (pooled_value !== want.value)
              note_mismatch($sformatf("pooled_value %0d, expected %0d",
                                      pooled_value, want.value));
            if (source_index !== want.index)
              note_mismatch($sformatf("source_index %0d, expected %0d",
                                      source_index, want.index));
            if (last_of_tensor !== want.last)
              note_mismatch($sformatf("last_of_tensor %b, expected %b at index %0d",
                                      last_of_tensor, want.last, want.index));
          end
        end
        @(posedge clk);
      end
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    push = 1'b0;
    sample = '0;
    write_enable = 1'b0;
    reg_index = '0;
    write_data = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    sent_items = 0;
    fail_count = 0;
    reset_prediction();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_value_extremes();
    test_ties_and_spare_regs();
    test_oversized_window();
    test_channel_limit();
    test_tall_plane();
    test_wide_saturated();
    test_large_window();
    test_random_shapes();

    settle_idle();
    if (pending_pools.size() == 0 && fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mp2_pkg.sv
rtl/core/mp2_cfg.sv
rtl/core/mp2_front.sv
rtl/core/mp2_job_queue.sv
rtl/core/mp2_back.sv
rtl/core/max_pool_2d_with_argmax.sv
bench/max_pool_2d_with_argmax_test.sv
